/* hw/rtl/gmfd_pkg.sv */
// ----------------------------------------------------------------------------
// gmfd_pkg: shared types and constants of the geared motor feedback decoder
// Widths, fixed-point constants, register indexes, state codes, saturation.
// ----------------------------------------------------------------------------
package gmfd_pkg;

    localparam int ANGLE_W  = 48;                   // output angle, Q32.16
    localparam int ROTOR_W  = 28;                   // rotor angle, Q.16
    localparam int DIFF_W   = ROTOR_W + 1;          // rotor angle change
    localparam int DELTA_W  = 30;                   // geared angle change
    localparam int FRAC_W   = 16;
    localparam int RAW_W    = 16;
    localparam int DATA_W   = 32;

    localparam int DIVD_W   = ANGLE_W;              // divider dividend
    localparam int DIVS_W   = 25;                   // divider divisor
    localparam int DCNT_W   = $clog2(DIVD_W + 1);

    localparam int MCAND_W  = 32;
    localparam int MPLIER_W = 17;
    localparam int PROD_W   = MCAND_W + MPLIER_W;
    localparam int MCNT_W   = $clog2(MPLIER_W + 1);

    localparam int ADDR_W   = 5;
    localparam int IDX_W    = 3;
    localparam int GEAR_W   = 17;

    localparam logic [DIVS_W-1:0]          ENC_COUNTS  = 25'd8191;
    localparam logic [DIVS_W-1:0]          FULL_TURN   = 25'd23592960;
    localparam logic signed [ANGLE_W-1:0]  HALF_TURN   = 48'sd11796480;
    localparam logic signed [DIFF_W-1:0]   DIFF_TURN   = 29'sd23592960;
    localparam logic signed [DIFF_W-1:0]   DIFF_LIMIT  = 29'sd19660800;
    localparam logic [RAW_W-1:0]           ANGLE_ROUND = 16'h0FFF;
    localparam logic [40:0]                NEG_BIAS    = 41'd8191;
    localparam logic signed [PROD_W-1:0]   ROUND_HALF  = 49'sd32768;

    localparam logic [GEAR_W-1:0]          GEAR_RESET   = 17'd65536;
    localparam logic signed [DATA_W-1:0]   CSCALE_RESET = 32'sd65536;
    localparam logic signed [DATA_W-1:0]   THRESH_RESET = 32'sh7FFFFFFF;

    localparam logic [IDX_W-1:0] REG_REVERSE = 3'd0;
    localparam logic [IDX_W-1:0] REG_ACCUM   = 3'd1;
    localparam logic [IDX_W-1:0] REG_GEAR    = 3'd2;
    localparam logic [IDX_W-1:0] REG_CSCALE  = 3'd3;
    localparam logic [IDX_W-1:0] REG_THRESH  = 3'd4;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_LOAD,
        ST_DIV_ROTOR,
        ST_UNWRAP,
        ST_MUL_GEAR,
        ST_SUM,
        ST_DIV_WRAP,
        ST_UPDATE
    } state_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-DATA_W:0] top;
        top = v[PROD_W-1:DATA_W-1];
        if (top == '0 || top == '1)
        begin
            return $signed(v[DATA_W-1:0]);
        end
        else if (v[PROD_W-1])
        begin
            return 32'sh80000000;
        end
        else
        begin
            return 32'sh7FFFFFFF;
        end
    endfunction

endpackage

/* hw/rtl/gmfd_serial_div.sv */
// ----------------------------------------------------------------------------
// gmfd_serial_div: bit-serial restoring divider
// One quotient bit per cycle over the full dividend width.
// ----------------------------------------------------------------------------
module gmfd_serial_div
    import gmfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic [DIVD_W-1:0] quotient,
    output logic [DIVS_W-1:0] remainder,
    output logic              done
);

    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              done_reg;

    logic [DIVS_W:0]   shifted;
    logic              ge;
    logic [DIVS_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[DIVD_W-1]};
    assign ge      = (shifted >= {1'b0, dvs_reg});
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == DCNT_W'(1));
            if (start)
            begin
                cnt_reg <= DCNT_W'(DIVD_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - DCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DIVD_W-2:0], ge};
            rem_reg <= ge ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

/* hw/rtl/gmfd_serial_mul.sv */
// ----------------------------------------------------------------------------
// gmfd_serial_mul: bit-serial shift-add multiplier
// Signed multiplicand, multiplier bits taken one per cycle, optional signed
// multiplier (top bit weighted negative). done stays high from the end of a
// product until the next start.
// ----------------------------------------------------------------------------
module gmfd_serial_mul
    import gmfd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [MCAND_W-1:0] mcand,
    input  logic [MPLIER_W-1:0]       mplier,
    input  logic                      mplier_signed,
    output logic signed [PROD_W-1:0]  product,
    output logic                      done
);

    logic signed [MCAND_W-1:0] mcand_reg;
    logic signed [MCAND_W:0]   hi_reg;
    logic [MPLIER_W-1:0]       lo_reg;
    logic                      sgn_reg;
    logic [MCNT_W-1:0]         cnt_reg;
    logic                      done_reg;

    logic signed [MCAND_W+1:0] addend;
    logic signed [MCAND_W+1:0] sum;
    logic [MCAND_W+MPLIER_W:0] prod_full;

    always_comb
    begin
        addend = lo_reg[0] ? (MCAND_W+2)'(mcand_reg) : '0;
        if (sgn_reg && cnt_reg == MCNT_W'(1))
        begin
            sum = (MCAND_W+2)'(hi_reg) - addend;
        end
        else
        begin
            sum = (MCAND_W+2)'(hi_reg) + addend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                cnt_reg  <= MCNT_W'(MPLIER_W);
                done_reg <= 1'b0;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - MCNT_W'(1);
                if (cnt_reg == MCNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= mcand;
            hi_reg    <= '0;
            lo_reg    <= mplier;
            sgn_reg   <= mplier_signed;
        end
        else if (cnt_reg != '0)
        begin
            hi_reg <= sum[MCAND_W+1:1];
            lo_reg <= {sum[0], lo_reg[MPLIER_W-1:1]};
        end
    end

    assign prod_full = {hi_reg, lo_reg};
    assign product   = $signed(prod_full[PROD_W-1:0]);
    assign done      = done_reg;

endmodule

/* hw/rtl/geared_motor_feedback_decoder.sv */
// ----------------------------------------------------------------------------
// geared_motor_feedback_decoder: motor feedback frame to output shaft angle
// Requests are taken one at a time: s_axis_tready is low from acceptance until
// the result is committed, which may wait for m_axis_tready. The work is set by
// the 48-step bit-serial divider (used once, or twice in wrap mode) and the
// 17-step serial gear multiply. rst_n clears state, registers to reset values.
// ----------------------------------------------------------------------------
module geared_motor_feedback_decoder
    import gmfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // APB configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [47:0]       s_axis_tdata,  // angle_raw, speed_raw, current_raw
    // output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [159:0]      m_axis_tdata   // output_angle, output_speed,
                                             // scaled_current, captured_angle
);

    state_t state_reg, state_next;

    logic                       reverse_reg;
    logic                       accum_reg;
    logic [GEAR_W-1:0]          gear_reg;
    logic signed [DATA_W-1:0]   cscale_reg;
    logic signed [DATA_W-1:0]   thresh_reg;

    logic [RAW_W-1:0]           ang_reg;
    logic [RAW_W-1:0]           spd_reg;
    logic [RAW_W-1:0]           cur_reg;
    logic                       rotor_neg_reg;
    logic signed [ROTOR_W-1:0]  rotor_reg;
    logic signed [DELTA_W-1:0]  delta_reg;
    logic                       wrap_neg_reg;
    logic signed [DATA_W-1:0]   speed_out_reg;
    logic                       m_valid_reg;

    logic signed [ROTOR_W-1:0]  prev_reg;
    logic signed [ANGLE_W-1:0]  total_reg;
    logic signed [DATA_W-1:0]   last_cur_reg;
    logic signed [ANGLE_W-1:0]  held_reg;
    logic signed [ANGLE_W-1:0]  total_next;

    logic                       wr_en;
    logic [IDX_W-1:0]           idx;
    logic                       s_accept;
    logic                       out_free;
    logic                       commit;
    logic                       div_start;
    logic                       div_wrap_sel;
    logic                       mul_load;
    logic                       gear_start;

    logic signed [24:0]         a_ext;
    logic signed [24:0]         a360;
    logic [40:0]                n_u;
    logic [40:0]                rotor_mag;
    logic [DIVD_W-1:0]          div_dividend;
    logic [DIVS_W-1:0]          div_divisor;
    logic [DIVD_W-1:0]          div_quotient;
    logic [DIVS_W-1:0]          div_remainder;
    logic                       div_done;

    logic signed [ROTOR_W-1:0]  q_s;
    logic signed [ROTOR_W-1:0]  rotor_calc;
    logic signed [DIFF_W-1:0]   d_raw;
    logic signed [DIFF_W-1:0]   d_adj;

    logic signed [PROD_W-1:0]   gear_prod;
    logic signed [PROD_W-1:0]   spd_prod;
    logic signed [PROD_W-1:0]   cur_prod;
    logic signed [PROD_W-1:0]   gear_round;
    logic                       gear_done;
    logic                       spd_done;
    logic                       cur_done;

    logic signed [ANGLE_W:0]    acc_sum;
    logic signed [ANGLE_W:0]    wrap_v;
    logic [ANGLE_W:0]           wrap_mag;
    logic signed [ANGLE_W-1:0]  acc_sat;
    logic [DIVS_W-1:0]          fmod;
    logic signed [ANGLE_W-1:0]  wrapped;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_reg <= 1'b0;
            accum_reg   <= 1'b0;
            gear_reg    <= GEAR_RESET;
            cscale_reg  <= CSCALE_RESET;
            thresh_reg  <= THRESH_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_REVERSE: reverse_reg <= pwdata[0];
                REG_ACCUM:   accum_reg   <= pwdata[0];
                REG_GEAR:    gear_reg    <= pwdata[GEAR_W-1:0];
                REG_CSCALE:  cscale_reg  <= $signed(pwdata);
                REG_THRESH:  thresh_reg  <= $signed(pwdata);
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_REVERSE: prdata = {{(DATA_W-1){1'b0}}, reverse_reg};
            REG_ACCUM:   prdata = {{(DATA_W-1){1'b0}}, accum_reg};
            REG_GEAR:    prdata = DATA_W'(gear_reg);
            REG_CSCALE:  prdata = cscale_reg;
            REG_THRESH:  prdata = thresh_reg;
            default:     prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_axis_tvalid) state_next = ST_LOAD;
            ST_LOAD:      state_next = ST_DIV_ROTOR;
            ST_DIV_ROTOR: if (div_done) state_next = ST_UNWRAP;
            ST_UNWRAP:    state_next = ST_MUL_GEAR;
            ST_MUL_GEAR:  if (gear_done) state_next = ST_SUM;
            ST_SUM:       state_next = accum_reg ? ST_UPDATE : ST_DIV_WRAP;
            ST_DIV_WRAP:  if (div_done) state_next = ST_UPDATE;
            ST_UPDATE:    if (out_free && spd_done && cur_done) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        div_wrap_sel  = 1'b0;
        mul_load      = 1'b0;
        gear_start    = 1'b0;
        commit        = 1'b0;
        case (state_reg)
            ST_IDLE:   s_axis_tready = 1'b1;
            ST_LOAD:
            begin
                div_start = 1'b1;
                mul_load  = 1'b1;
            end
            ST_UNWRAP: gear_start = 1'b1;
            ST_SUM:
            begin
                div_start    = !accum_reg;
                div_wrap_sel = 1'b1;
            end
            ST_UPDATE: commit = out_free && spd_done && cur_done;
            default:   ;
        endcase
    end

    // ---------------- rotor angle in degrees ----------------
    // rotor + 180 = floor((a*360*65536 + 4095) / 8191); negative numerators
    // use floor(n/d) = -floor((-n + d - 1) / d)
    assign a_ext     = 25'($signed(ang_reg));
    assign a360      = (a_ext <<< 8) + (a_ext <<< 6) + (a_ext <<< 5) + (a_ext <<< 3);
    assign n_u       = {a360, ANGLE_ROUND};
    assign rotor_mag = a360[24] ? (~n_u + NEG_BIAS) : n_u;

    assign div_dividend = div_wrap_sel ? wrap_mag[DIVD_W-1:0] : DIVD_W'(rotor_mag);
    assign div_divisor  = div_wrap_sel ? FULL_TURN : ENC_COUNTS;

    gmfd_serial_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .done      (div_done)
    );

    assign q_s        = $signed(div_quotient[ROTOR_W-1:0]);
    assign rotor_calc = (rotor_neg_reg ? -q_s : q_s) - ROTOR_W'(HALF_TURN);

    // ---------------- unwrap ----------------
    assign d_raw = DIFF_W'(rotor_reg) - DIFF_W'(prev_reg);

    always_comb
    begin
        if (d_raw > DIFF_LIMIT)
        begin
            d_adj = d_raw - DIFF_TURN;
        end
        else if (d_raw < -DIFF_LIMIT)
        begin
            d_adj = d_raw + DIFF_TURN;
        end
        else
        begin
            d_adj = d_raw;
        end
    end

    // ---------------- multipliers ----------------
    gmfd_serial_mul u_mul_gear
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (gear_start),
        .mcand         (MCAND_W'(d_adj)),
        .mplier        (gear_reg),
        .mplier_signed (1'b0),
        .product       (gear_prod),
        .done          (gear_done)
    );

    gmfd_serial_mul u_mul_speed
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (mul_load),
        .mcand         (MCAND_W'($signed(spd_reg))),
        .mplier        (gear_reg),
        .mplier_signed (1'b0),
        .product       (spd_prod),
        .done          (spd_done)
    );

    gmfd_serial_mul u_mul_cur
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (mul_load),
        .mcand         (cscale_reg),
        .mplier        (MPLIER_W'($signed(cur_reg))),
        .mplier_signed (1'b1),
        .product       (cur_prod),
        .done          (cur_done)
    );

    assign gear_round = gear_prod + ROUND_HALF;

    // ---------------- accumulate / wrap ----------------
    assign acc_sum  = (ANGLE_W+1)'(total_reg) + (ANGLE_W+1)'(delta_reg);
    assign wrap_v   = acc_sum + (ANGLE_W+1)'(HALF_TURN);
    assign wrap_mag = wrap_v[ANGLE_W] ? -wrap_v : wrap_v;

    always_comb
    begin
        if (acc_sum[ANGLE_W] != acc_sum[ANGLE_W-1])
        begin
            acc_sat = acc_sum[ANGLE_W] ? {1'b1, {(ANGLE_W-1){1'b0}}}
                                       : {1'b0, {(ANGLE_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_sum[ANGLE_W-1:0];
        end
    end

    assign fmod       = (wrap_neg_reg && div_remainder != '0) ? FULL_TURN - div_remainder
                                                             : div_remainder;
    assign wrapped    = $signed(ANGLE_W'(fmod)) - HALF_TURN;
    assign total_next = accum_reg ? acc_sat : wrapped;

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            ang_reg <= reverse_reg ? (RAW_W'(0) - s_axis_tdata[15:0])  : s_axis_tdata[15:0];
            spd_reg <= reverse_reg ? (RAW_W'(0) - s_axis_tdata[31:16]) : s_axis_tdata[31:16];
            cur_reg <= reverse_reg ? (RAW_W'(0) - s_axis_tdata[47:32]) : s_axis_tdata[47:32];
        end
        if (state_reg == ST_LOAD)
        begin
            rotor_neg_reg <= a360[24];
        end
        if (state_reg == ST_DIV_ROTOR && div_done)
        begin
            rotor_reg <= rotor_calc;
        end
        if (state_reg == ST_MUL_GEAR && gear_done)
        begin
            delta_reg <= $signed(gear_round[FRAC_W+DELTA_W-1:FRAC_W]);
        end
        if (state_reg == ST_SUM)
        begin
            wrap_neg_reg <= wrap_v[ANGLE_W];
        end
        if (commit)
        begin
            speed_out_reg <= sat32(spd_prod);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg     <= '0;
            total_reg    <= '0;
            last_cur_reg <= '0;
            held_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                prev_reg     <= rotor_reg;
                total_reg    <= total_next;
                last_cur_reg <= sat32(cur_prod);
                if (last_cur_reg >= thresh_reg)
                begin
                    held_reg <= total_next;
                end
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {held_reg, last_cur_reg, speed_out_reg, total_reg};

endmodule

/* hw/rtl/gmfd_checker.sv */
// ----------------------------------------------------------------------------
// gmfd_checker: port-level checks of the geared motor feedback decoder
// Bound to the top level; watches the two stream handshakes.
// ----------------------------------------------------------------------------
module gmfd_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [159:0] m_axis_tdata
);

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after a request");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a request in progress");

    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("input not ready once a result is posted");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

endmodule

bind geared_motor_feedback_decoder gmfd_checker u_gmfd_checker (.*);
